// ----- rtl/core/gas_pkg.sv -----
// shared types, constants and saturation helper for the global alignment score unit
// no dependencies
package gas_pkg;

  localparam int MAX_QUERY = 128;
  localparam int SCORE_W   = 13;
  localparam int CFG_W     = 5;
  localparam int SYM_W     = 8;
  localparam int POS_W     = 16;
  localparam int QLEN_W    = $clog2(MAX_QUERY + 1);

  localparam logic signed [SCORE_W-1:0] SCORE_MAX = 13'sd4095;
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = -13'sd4096;
  localparam logic [POS_W-1:0]          POS_MAX   = '1;

  typedef enum logic [1:0] {
    REG_MATCH    = 2'd0,
    REG_MISMATCH = 2'd1,
    REG_GAP      = 2'd2
  } gas_reg_e;

  typedef enum logic {
    ACT_QUERY  = 1'b0,
    ACT_TARGET = 1'b1
  } gas_act_e;

  typedef struct packed {
    logic signed [CFG_W-1:0] match_score;
    logic signed [CFG_W-1:0] mismatch_score;
    logic signed [CFG_W-1:0] gap_score;
  } gas_cfg_t;

  // wavefront token handed from cell to cell
  typedef struct packed {
    logic                      valid;
    logic                      fresh;     // first target symbol of an alignment
    logic signed [SCORE_W-1:0] left_new;  // new score of the left neighbor
    logic signed [SCORE_W-1:0] diag;      // old score of the left neighbor
  } gas_tok_t;

  function automatic logic signed [SCORE_W-1:0] gas_sat(input logic signed [SCORE_W:0] x);
    logic signed [SCORE_W-1:0] r;
    if (x > (SCORE_W+1)'(SCORE_MAX)) begin
      r = SCORE_MAX;
    end else if (x < (SCORE_W+1)'(SCORE_MIN)) begin
      r = SCORE_MIN;
    end else begin
      r = x[SCORE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/global_alignment_score_unit.sv -----
// global alignment score unit: query load, border stage, chain of score cells, result register
// depends on gas_pkg and gas_cell
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: symbol; tuser: action; tlast: is_last
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: alignment_score, target_position;
//                                             tlast: final_res
// cfg       in   cfg_we_i                     cfg_idx_i, cfg_data_i
//
// a query request gives no result
// a target request holds the input until its wavefront is done; its result is registered
// once the wavefront reaches the last query cell, the wavefront moving one cell per cycle
// the input is stalled while a wavefront runs or the result register is full and not drained
// reset clears control state and the query length; no clearing pass
module global_alignment_score_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [gas_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] symbol
  input  logic                          s_axis_tuser,   // [0] action
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,   // [12:0] alignment_score, [28:13] target_position
  output logic                          m_axis_tlast
);
  import gas_pkg::*;

  gas_cfg_t                  cfg_q;
  logic [QLEN_W-1:0]         qlen_q, qlen_d;
  logic                      qopen_q, qopen_d;
  logic [POS_W-1:0]          tcnt_q, tcnt_d, tcnt_inc;
  logic signed [SCORE_W-1:0] border_q, border_d;
  logic                      busy_q, busy_d;
  logic [QLEN_W-1:0]         pos_q, pos_d;
  logic                      done;
  logic                      accept, q_acc, t_acc;
  logic [QLEN_W-1:0]         wr_addr;
  logic                      wr_ok;
  logic [SYM_W-1:0]          tsym_q;
  logic signed [SCORE_W:0]   border_sum;
  logic signed [SCORE_W-1:0] diag0;
  logic                      fresh;
  gas_tok_t                  tok0_d;
  gas_tok_t                  tok0_q;
  gas_tok_t                  tok [MAX_QUERY+1];
  logic                      mvalid_q, mvalid_d;
  logic signed [SCORE_W-1:0] oscore_q;
  logic [POS_W-1:0]          opos_q;
  logic                      olast_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.match_score    <= 5'sd1;
      cfg_q.mismatch_score <= -5'sd1;
      cfg_q.gap_score      <= -5'sd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MATCH:    cfg_q.match_score    <= cfg_data_i;
        REG_MISMATCH: cfg_q.mismatch_score <= cfg_data_i;
        REG_GAP:      cfg_q.gap_score      <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  assign s_axis_tready = !busy_q && (!mvalid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign q_acc         = accept && (s_axis_tuser == ACT_QUERY);
  assign t_acc         = accept && (s_axis_tuser == ACT_TARGET);
  assign done          = busy_q && (pos_q == qlen_q);

  // query load
  always_comb begin
    wr_addr = qopen_q ? qlen_q : '0;
    wr_ok   = (wr_addr < QLEN_W'(MAX_QUERY));
    qlen_d  = qlen_q;
    qopen_d = qopen_q;
    if (q_acc) begin
      qlen_d  = wr_ok ? wr_addr + 1'b1 : wr_addr;
      qopen_d = !s_axis_tlast;
    end else if (t_acc) begin
      qopen_d = 1'b0;
    end
  end

  // border stage and target count
  always_comb begin
    fresh      = (tcnt_q == '0);
    diag0      = fresh ? '0 : border_q;
    border_sum = (SCORE_W+1)'(diag0) + (SCORE_W+1)'(cfg_q.gap_score);
    tcnt_inc   = (tcnt_q == POS_MAX) ? POS_MAX : tcnt_q + 1'b1;
    border_d   = border_q;
    tcnt_d     = tcnt_q;
    tok0_d.valid    = t_acc;
    tok0_d.fresh    = fresh;
    tok0_d.left_new = gas_sat(border_sum);
    tok0_d.diag     = diag0;
    if (q_acc) begin
      tcnt_d = '0;
    end else if (t_acc) begin
      border_d = gas_sat(border_sum);
      tcnt_d   = s_axis_tlast ? '0 : tcnt_inc;
    end
  end

  // wavefront control
  always_comb begin
    busy_d = busy_q;
    pos_d  = pos_q;
    if (t_acc) begin
      busy_d = 1'b1;
      pos_d  = '0;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (busy_q) begin
      pos_d = pos_q + 1'b1;
    end
  end

  always_comb begin
    mvalid_d = mvalid_q;
    if (done) begin
      mvalid_d = 1'b1;
    end else if (m_axis_tready) begin
      mvalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qlen_q     <= '0;
      qopen_q    <= 1'b0;
      tcnt_q     <= '0;
      border_q   <= '0;
      busy_q     <= 1'b0;
      pos_q      <= '0;
      mvalid_q   <= 1'b0;
      tok0_q     <= '0;
    end else begin
      qlen_q     <= qlen_d;
      qopen_q    <= qopen_d;
      tcnt_q     <= tcnt_d;
      border_q   <= border_d;
      busy_q     <= busy_d;
      pos_q      <= pos_d;
      mvalid_q   <= mvalid_d;
      if (t_acc) begin
        tok0_q <= tok0_d;
      end else begin
        tok0_q.valid <= 1'b0;
      end
    end
  end

  assign tok[0] = tok0_q;

  always_ff @(posedge clk_i) begin
    if (t_acc) begin
      tsym_q          <= s_axis_tdata;
      opos_q          <= tcnt_inc;
      olast_q         <= s_axis_tlast;
    end
    if (done) begin
      oscore_q <= tok[pos_q].left_new;
    end
  end

  // chain of cells
  for (genvar i = 1; i <= MAX_QUERY; i++) begin : g_cell
    gas_tok_t tok_in;
    logic     wr_en;

    always_comb begin
      tok_in       = tok[i-1];
      tok_in.valid = tok[i-1].valid && !done;
      wr_en        = q_acc && wr_ok && (wr_addr == QLEN_W'(i - 1));
    end

    gas_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cfg_i        (cfg_q),
      .target_sym_i (tsym_q),
      .wr_en_i      (wr_en),
      .wr_sym_i     (s_axis_tdata),
      .tok_i        (tok_in),
      .tok_o        (tok[i])
    );
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = {3'b000, opos_q, oscore_q};
  assign m_axis_tlast  = olast_q;

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pos_q <= qlen_q))
    else $error("wavefront position beyond query length");

  a_qlen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qlen_q <= QLEN_W'(MAX_QUERY))
    else $error("query length beyond depth");

  a_done_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> m_axis_tvalid)
    else $error("finished wavefront gave no result");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !s_axis_tready)
    else $error("request accepted during wavefront");

endmodule

// ----- rtl/core/gas_cell.sv -----
// one query position of the score row: holds its query symbol and row score
// depends on gas_pkg
module gas_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gas_pkg::gas_cfg_t             cfg_i,
  input  logic [gas_pkg::SYM_W-1:0]     target_sym_i,
  input  logic                          wr_en_i,
  input  logic [gas_pkg::SYM_W-1:0]     wr_sym_i,
  input  gas_pkg::gas_tok_t             tok_i,
  output gas_pkg::gas_tok_t             tok_o
);
  import gas_pkg::*;

  logic [SYM_W-1:0]          qsym_q;
  logic signed [SCORE_W-1:0] score_q;
  logic signed [SCORE_W-1:0] up;
  logic signed [SCORE_W-1:0] new_score;
  logic signed [CFG_W-1:0]   sub_score;
  logic signed [SCORE_W:0]   diag_sum;
  logic signed [SCORE_W:0]   left_sum;
  logic signed [SCORE_W:0]   up_sum;
  logic signed [SCORE_W:0]   best;
  gas_tok_t                  tok_d;
  gas_tok_t                  tok_q;

  always_comb begin
    up        = tok_i.fresh ? gas_sat((SCORE_W+1)'(tok_i.diag) + (SCORE_W+1)'(cfg_i.gap_score))
                            : score_q;
    sub_score = (qsym_q == target_sym_i) ? cfg_i.match_score : cfg_i.mismatch_score;
    diag_sum  = (SCORE_W+1)'(tok_i.diag) + (SCORE_W+1)'(sub_score);
    left_sum  = (SCORE_W+1)'(tok_i.left_new) + (SCORE_W+1)'(cfg_i.gap_score);
    up_sum    = (SCORE_W+1)'(up) + (SCORE_W+1)'(cfg_i.gap_score);
    best      = diag_sum;
    if (left_sum > best) best = left_sum;
    if (up_sum > best) best = up_sum;
    new_score = gas_sat(best);
    tok_d.valid    = tok_i.valid;
    tok_d.fresh    = tok_i.fresh;
    tok_d.left_new = new_score;
    tok_d.diag     = up;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      qsym_q <= wr_sym_i;
    end
    if (tok_i.valid) begin
      score_q <= new_score;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else if (tok_i.valid) begin
      tok_q <= tok_d;
    end else begin
      tok_q.valid <= 1'b0;
    end
  end

  assign tok_o = tok_q;

endmodule
